FILE: hdl/t2a_pkg.sv
// Shared types, codes, markup strings and table lookups for the teletext transcoder.
`default_nettype none
package t2a_pkg;

  // Control byte codes
  localparam logic [7:0] CodeColorLo  = 8'h01;
  localparam logic [7:0] CodeColorHi  = 8'h07;
  localparam logic [7:0] CodeFlash    = 8'h08;
  localparam logic [7:0] CodeSteady   = 8'h09;
  localparam logic [7:0] CodeEndBox   = 8'h0A;
  localparam logic [7:0] CodeStartBox = 8'h0B;
  localparam logic [7:0] CodeMosBase  = 8'h10;
  localparam logic [7:0] CodeMosHi    = 8'h17;
  localparam logic [7:0] CodeConceal  = 8'h18;
  localparam logic [7:0] CodeContig   = 8'h19;
  localparam logic [7:0] CodeSepar    = 8'h1A;
  localparam logic [7:0] CodeEscape   = 8'h1B;
  localparam logic [7:0] CodeBlackBg  = 8'h1C;
  localparam logic [7:0] CodeNewBg    = 8'h1D;
  localparam logic [7:0] CodeRelease  = 8'h1F;
  localparam logic [7:0] CodePrintLo  = 8'h20;
  localparam logic [7:0] CodePrintHi  = 8'h7E;

  localparam logic [1:0] HdrBytes = 2'd2;

  localparam logic [23:0] PALETTE [8] = '{
    24'h000000, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  localparam logic [0:4][7:0]  S_COLOR_HEAD = "{\\c&H";
  localparam logic [0:9][7:0]  S_FLASH_ON   = "{\\1a&H00&}";
  localparam logic [0:9][7:0]  S_FLASH_OFF  = "{\\1a&HFF&}";
  localparam logic [0:3][7:0]  S_COLOR_RST  = "{\\c}";
  localparam logic [0:4][7:0]  S_BOLD       = "{\\b1}";
  localparam logic [0:13][7:0] S_BORDER     = "{\\3c&H000000&}";
  localparam logic [0:4][7:0]  S_BORDER_RST = "{\\3c}";
  localparam logic [0:2][7:0]  S_BLOCK      = {8'hE2, 8'h96, 8'h88};
  localparam logic [7:0]       ChAmp        = 8'h26;
  localparam logic [7:0]       ChClose      = 8'h7D;

  typedef enum logic [3:0] {
    RUN_MARK,
    RUN_CHAR,
    RUN_BLOCK,
    RUN_COLOR,
    RUN_FLASH_ON,
    RUN_FLASH_OFF,
    RUN_COLOR_RST,
    RUN_BOLD,
    RUN_BORDER,
    RUN_BORDER_RST
  } run_e;

  typedef struct packed {
    logic [1:0] pos;
    logic       flash;
    logic       mosaic;
    logic       esc;
  } state_t;

  typedef struct packed {
    run_e       kind;
    logic [7:0] arg;       // literal byte or color code
    logic       pkt_last;
  } desc_t;

  function automatic logic [3:0] run_len(input run_e kind);
    logic [3:0] len;
    case (kind)
      RUN_MARK:       len = 4'd1;
      RUN_CHAR:       len = 4'd1;
      RUN_BLOCK:      len = 4'd3;
      RUN_COLOR:      len = 4'd13;
      RUN_FLASH_ON:   len = 4'd10;
      RUN_FLASH_OFF:  len = 4'd10;
      RUN_COLOR_RST:  len = 4'd4;
      RUN_BOLD:       len = 4'd5;
      RUN_BORDER:     len = 4'd14;
      RUN_BORDER_RST: len = 4'd5;
      default:        len = 4'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = {4'h0, nib} + 8'h30;
    else             c = {4'h0, nib} + 8'h57;
    return c;
  endfunction

  // Color tag byte: header, six hex digits, then "&}"
  function automatic logic [7:0] color_byte(input logic [2:0] code, input logic [3:0] idx);
    logic [23:0] col;
    logic [3:0]  nib;
    logic [7:0]  c;
    col = PALETTE[code];
    case (idx)
      4'd5:    nib = col[23:20];
      4'd6:    nib = col[19:16];
      4'd7:    nib = col[15:12];
      4'd8:    nib = col[11:8];
      4'd9:    nib = col[7:4];
      default: nib = col[3:0];
    endcase
    if (idx < 4'd5)       c = S_COLOR_HEAD[idx[2:0]];
    else if (idx < 4'd11) c = hex_char(nib);
    else if (idx == 4'd11) c = ChAmp;
    else                  c = ChClose;
    return c;
  endfunction

  function automatic logic [7:0] run_byte(input desc_t d, input logic [3:0] idx);
    logic [7:0] c;
    case (d.kind)
      RUN_MARK:       c = 8'h00;
      RUN_CHAR:       c = d.arg;
      RUN_BLOCK:      c = S_BLOCK[idx[1:0]];
      RUN_COLOR:      c = color_byte(d.arg[2:0], idx);
      RUN_FLASH_ON:   c = S_FLASH_ON[idx];
      RUN_FLASH_OFF:  c = S_FLASH_OFF[idx];
      RUN_COLOR_RST:  c = S_COLOR_RST[idx[1:0]];
      RUN_BOLD:       c = S_BOLD[idx[2:0]];
      RUN_BORDER:     c = S_BORDER[idx];
      RUN_BORDER_RST: c = S_BORDER_RST[idx[2:0]];
      default:        c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/teletext_to_ass_transcoder.sv
// Top level: teletext subtitle byte stream in, subtitle markup text stream out.
//
// Usage:
//   s_axis carries the packet one byte per beat; s_axis_tlast marks the final
//   byte. The first two bytes of each packet are header and emit nothing.
//   m_axis carries the markup text one byte per beat. tuser[0] flags a real
//   character (low only on the bare end-of-packet marker sent when the last
//   byte emits nothing), tuser[1] flags the last beat caused by one input
//   byte, and m_axis_tlast flags the final beat of the packet.
// Decode: an input byte is decoded in the cycle it is accepted; its run is
//   registered into the run register, or into the holding register while a run is being sent.
// Throughput: the output side moves one beat per cycle while m_axis_tready
//   is high; an input byte emits one byte for plain text, three for a
//   mosaic block, up to fourteen for a tag; silent bytes cost none of the
//   output side. One decoded run waits in a holding register behind the run
//   being sent, so input is taken while the receiver stalls until that
//   holding register is full.
// Reset: clears the packet state (header count, flash, mosaic, escape) and
//   drops any run in flight. The same state is cleared after every last byte.
`default_nettype none
module teletext_to_ass_transcoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // packet_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic [1:0]      m_axis_tuser,   // [0] char_valid, [1] run_last
  output logic            m_axis_tlast    // packet_end
);

  t2a_pkg::state_t st_q, st_d;
  logic            dec_emit;
  t2a_pkg::desc_t  dec_desc;

  // run being sent, and one run waiting behind it
  logic            run_vld_q;
  t2a_pkg::desc_t  run_q;
  logic [3:0]      idx_q;
  logic            pend_vld_q;
  t2a_pkg::desc_t  pend_q;

  logic            in_beat;
  logic            out_beat;
  logic            run_end;
  logic            run_free;
  logic [3:0]      run_n;

  t2a_decode u_decode (
    .data_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .st_i   (st_q),
    .st_o   (st_d),
    .emit_o (dec_emit),
    .desc_o (dec_desc)
  );

  assign s_axis_tready = !pend_vld_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign run_n    = t2a_pkg::run_len(run_q.kind);
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign run_end  = (idx_q == run_n - 4'd1);
  assign run_free = !run_vld_q || (out_beat && run_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_beat) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (run_free) begin
        idx_q <= '0;
        if (pend_vld_q) begin
          // input is stalled while the holding register is full
          run_vld_q  <= 1'b1;
          pend_vld_q <= 1'b0;
        end else begin
          run_vld_q <= in_beat && dec_emit;
        end
      end else begin
        if (out_beat) idx_q <= idx_q + 4'd1;
        if (in_beat && dec_emit) pend_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_free) begin
      if (pend_vld_q) run_q <= pend_q;
      else if (in_beat && dec_emit) run_q <= dec_desc;
    end else if (in_beat && dec_emit) begin
      pend_q <= dec_desc;
    end
  end

  assign m_axis_tvalid   = run_vld_q;
  assign m_axis_tdata    = t2a_pkg::run_byte(run_q, idx_q);
  assign m_axis_tuser[0] = (run_q.kind != t2a_pkg::RUN_MARK);
  assign m_axis_tuser[1] = run_end;
  assign m_axis_tlast    = run_end && run_q.pkt_last;

  // holding register only fills behind a busy run
  a_pend_behind_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> run_vld_q)
    else $error("pending run without active run");

  // beat index stays inside the run
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q |-> (idx_q < run_n))
    else $error("run index out of range");

  // packet end always coincides with the last beat of a run
  a_end_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
    else $error("packet end not on run boundary");

  // last byte returns the packet state to reset
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tlast) |=> (st_q == '0))
    else $error("state not cleared after packet");

  // a stalled beat keeps its byte while the run holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(idx_q)))
    else $error("stalled run advanced");

endmodule
`default_nettype wire

FILE: hdl/t2a_decode.sv
// Byte decoder: next packet state and the run descriptor for one input byte.
`default_nettype none
module t2a_decode (
  input  wire logic [7:0]      data_i,
  input  wire logic            last_i,
  input  wire t2a_pkg::state_t st_i,
  output t2a_pkg::state_t      st_o,
  output logic                 emit_o,
  output t2a_pkg::desc_t       desc_o
);

  t2a_pkg::state_t st;
  logic            act;
  logic            has_run;
  t2a_pkg::run_e   kind;
  logic [7:0]      arg;

  always_comb begin
    st      = st_i;
    act     = 1'b0;
    has_run = 1'b0;
    kind    = t2a_pkg::RUN_MARK;
    arg     = data_i;

    if (st_i.pos < t2a_pkg::HdrBytes) begin
      st.pos = st_i.pos + 2'd1;
    end else if (st_i.esc) begin
      st.esc = 1'b0;
    end else begin
      act = 1'b1;
    end

    if (act) begin
      if (data_i >= t2a_pkg::CodeColorLo && data_i <= t2a_pkg::CodeColorHi) begin
        has_run = 1'b1;
        kind    = t2a_pkg::RUN_COLOR;
      end else if (data_i >= t2a_pkg::CodeMosBase && data_i <= t2a_pkg::CodeMosHi) begin
        st.mosaic = 1'b1;
        if (data_i != t2a_pkg::CodeMosBase) begin
          has_run = 1'b1;
          kind    = t2a_pkg::RUN_COLOR;
        end
      end else if (data_i >= t2a_pkg::CodePrintLo && data_i <= t2a_pkg::CodePrintHi) begin
        has_run = 1'b1;
        kind    = st_i.mosaic ? t2a_pkg::RUN_BLOCK : t2a_pkg::RUN_CHAR;
      end else begin
        case (data_i)
          t2a_pkg::CodeFlash: begin
            if (!st_i.flash) begin
              st.flash = 1'b1;
              has_run  = 1'b1;
              kind     = t2a_pkg::RUN_FLASH_ON;
            end
          end
          t2a_pkg::CodeSteady: begin
            if (st_i.flash) begin
              st.flash = 1'b0;
              has_run  = 1'b1;
              kind     = t2a_pkg::RUN_FLASH_OFF;
            end
          end
          t2a_pkg::CodeEndBox: begin
            has_run = 1'b1;
            kind    = t2a_pkg::RUN_COLOR_RST;
          end
          t2a_pkg::CodeStartBox: begin
            has_run = 1'b1;
            kind    = t2a_pkg::RUN_BOLD;
          end
          t2a_pkg::CodeConceal: begin
            has_run = 1'b1;
            kind    = t2a_pkg::RUN_FLASH_OFF;
          end
          t2a_pkg::CodeContig:  st.mosaic = 1'b1;
          t2a_pkg::CodeSepar:   st.mosaic = 1'b0;
          t2a_pkg::CodeRelease: st.mosaic = 1'b0;
          t2a_pkg::CodeEscape:  st.esc    = 1'b1;
          t2a_pkg::CodeBlackBg: begin
            has_run = 1'b1;
            kind    = t2a_pkg::RUN_BORDER;
          end
          t2a_pkg::CodeNewBg: begin
            has_run = 1'b1;
            kind    = t2a_pkg::RUN_BORDER_RST;
          end
          default: ;
        endcase
      end
    end

    // packet end returns everything to reset
    if (last_i) st = '0;

    st_o            = st;
    emit_o          = has_run | last_i;
    desc_o.kind     = kind;
    desc_o.arg      = arg;
    desc_o.pkt_last = last_i;
  end

endmodule
`default_nettype wire
